@@ src/lcmlt_pkg.sv @@
`default_nettype none
package lcmlt_pkg;

    localparam int SLOPE_W   = 32;
    localparam int ICPT_W    = 48;
    localparam int X_W       = 16;
    localparam int CFG_W     = 16;
    localparam int REG_IDX_W = 8;
    // Left end and midpoint of any node: range_left plus up to 2^16 - 1.
    localparam int LO_W      = 18;
    localparam int DIFF_W    = SLOPE_W + 1;
    localparam int DC_W      = ICPT_W + 1;
    localparam int PROD_W    = DIFF_W + LO_W;
    localparam int VAL_W     = PROD_W + 1;
    localparam int BV_W      = 50;
    // Node index within a level; enough for the deepest level allowed.
    localparam int IDX_W     = 16;
    localparam int LINE_W    = 1 + SLOPE_W + ICPT_W;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_RANGE_LEFT   = 8'd0;
    localparam logic [REG_IDX_W-1:0] REG_KEEP_MAXIMUM = 8'd1;

    localparam logic signed [SLOPE_W-1:0] SLOPE_LIM = 32'sh7fff_ffff;
    localparam logic signed [ICPT_W-1:0]  ICPT_LIM  = 48'sh7fff_ffff_ffff;

    // One item walking down the chain. For a query, m and c hold the best
    // line found so far and bv its value at x.
    typedef struct packed {
        logic                      op;
        logic signed [SLOPE_W-1:0] m;
        logic signed [ICPT_W-1:0]  c;
        logic signed [X_W-1:0]     x;
        logic signed [LO_W-1:0]    lo;
        logic [IDX_W-1:0]          idx;
        logic                      have;
        logic signed [VAL_W-1:0]   bv;
    } tok_t;

    typedef struct packed {
        logic             active;
        logic [IDX_W-1:0] addr;
    } clr_t;

endpackage
`default_nettype wire

@@ src/lcmlt_in_if.sv @@
`default_nettype none
interface lcmlt_in_if;
    logic                                      valid;
    logic                                      ready;
    logic                                      op;
    logic signed [lcmlt_pkg::SLOPE_W-1:0]      line_slope;
    logic signed [lcmlt_pkg::ICPT_W-1:0]       line_intercept;
    logic signed [lcmlt_pkg::X_W-1:0]          query_x;

    modport source (output valid, op, line_slope, line_intercept, query_x, input ready);
    modport sink   (input valid, op, line_slope, line_intercept, query_x, output ready);
endinterface
`default_nettype wire

@@ src/lcmlt_out_if.sv @@
`default_nettype none
interface lcmlt_out_if;
    logic                                      valid;
    logic                                      ready;
    logic                                      found;
    logic signed [lcmlt_pkg::SLOPE_W-1:0]      best_slope;
    logic signed [lcmlt_pkg::ICPT_W-1:0]       best_intercept;
    logic signed [lcmlt_pkg::BV_W-1:0]         best_value;

    modport source (output valid, found, best_slope, best_intercept, best_value, input ready);
    modport sink   (input valid, found, best_slope, best_intercept, best_value, output ready);
endinterface
`default_nettype wire

@@ src/lcmlt_ram.sv @@
`default_nettype none
module lcmlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                    clk,
    input  wire logic                    we,
    input  wire logic [AW-1:0]           waddr,
    input  wire logic [WIDTH-1:0]        wdata,
    input  wire logic                    re,
    input  wire logic [AW-1:0]           raddr,
    output logic      [WIDTH-1:0]        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

@@ src/lcmlt_cell.sv @@
`default_nettype none
module lcmlt_cell #(
    parameter int LOG_RANGE = 10,
    parameter int LEVEL     = 0
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lcmlt_pkg::clr_t   clr,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire lcmlt_pkg::tok_t   in_tok,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output lcmlt_pkg::tok_t        out_tok
);
    localparam int  DEPTH = 1 << LEVEL;
    localparam int  AW    = (LEVEL > 0) ? LEVEL : 1;
    localparam bit  LAST  = (LEVEL == LOG_RANGE);
    localparam int  HALF  = (LEVEL < LOG_RANGE) ? (1 << (LOG_RANGE - LEVEL - 1)) : 0;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_READ = 6'b000010,
        S_MLO  = 6'b000100,
        S_MMID = 6'b001000,
        S_FIN  = 6'b010000,
        S_SEND = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    lcmlt_pkg::tok_t tok_reg, tok_next;

    logic signed [lcmlt_pkg::SLOPE_W-1:0] s_reg;
    logic signed [lcmlt_pkg::ICPT_W-1:0]  t_reg;
    logic                                 nv_reg;
    logic signed [lcmlt_pkg::DIFF_W-1:0]  dm_reg;
    logic signed [lcmlt_pkg::DC_W-1:0]    dc_reg;
    logic signed [lcmlt_pkg::PROD_W-1:0]  prod_reg;
    logic signed [lcmlt_pkg::VAL_W-1:0]   qv_reg;
    logic                                 blo_reg;

    logic [lcmlt_pkg::LINE_W-1:0] rdata;
    logic [lcmlt_pkg::LINE_W-1:0] wdata;
    logic [AW-1:0]                waddr;
    logic                         we;
    logic                         ins_we;

    logic signed [lcmlt_pkg::DIFF_W-1:0] mul_a;
    logic signed [lcmlt_pkg::LO_W-1:0]   mul_b;
    logic signed [lcmlt_pkg::PROD_W-1:0] prod;
    logic signed [lcmlt_pkg::LO_W-1:0]   mid;
    logic signed [lcmlt_pkg::VAL_W-1:0]  sum;
    logic                                bmid;
    logic                                qbetter;
    logic                                go_left;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_SEND);
    assign out_tok   = tok_reg;

    assign mid = tok_reg.lo + lcmlt_pkg::LO_W'(HALF);

    // One shared multiplier: line difference at lo then at mid for an insert,
    // stored line at x for a query.
    assign mul_a = (tok_reg.op == lcmlt_pkg::OP_QUERY) ? lcmlt_pkg::DIFF_W'(s_reg) : dm_reg;
    assign mul_b = (state_reg == S_MMID) ? mid :
                   (tok_reg.op == lcmlt_pkg::OP_QUERY) ? lcmlt_pkg::LO_W'(tok_reg.x) :
                   tok_reg.lo;
    assign prod  = mul_a * mul_b;

    assign sum = (tok_reg.op == lcmlt_pkg::OP_QUERY && state_reg == S_MMID) ?
                 lcmlt_pkg::VAL_W'(prod_reg) + lcmlt_pkg::VAL_W'(t_reg) :
                 lcmlt_pkg::VAL_W'(prod_reg) + lcmlt_pkg::VAL_W'(dc_reg);

    assign bmid    = sum[lcmlt_pkg::VAL_W-1];
    assign qbetter = nv_reg && (!tok_reg.have || qv_reg < tok_reg.bv);
    assign go_left = (tok_reg.op == lcmlt_pkg::OP_QUERY) ?
                     (lcmlt_pkg::LO_W'(tok_reg.x) < mid) : (blo_reg != bmid);

    assign ins_we = (state_reg == S_FIN) && (tok_reg.op == lcmlt_pkg::OP_INSERT)
                    && (!nv_reg || bmid);

    always_comb
    begin
        if (clr.active)
        begin
            we    = 1'b1;
            waddr = clr.addr[AW-1:0];
            wdata = '0;
        end
        else
        begin
            we    = ins_we;
            waddr = tok_reg.idx[AW-1:0];
            wdata = {1'b1, tok_reg.m, tok_reg.c};
        end
    end

    lcmlt_ram #(
        .WIDTH (lcmlt_pkg::LINE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (in_valid && in_ready),
        .raddr (in_tok.idx[AW-1:0]),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        tok_next   = tok_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_READ;
                    tok_next   = in_tok;
                end
            end
            S_READ: state_next = S_MLO;
            S_MLO:  state_next = S_MMID;
            S_MMID: state_next = S_FIN;
            S_FIN:
            begin
                if (tok_reg.op == lcmlt_pkg::OP_QUERY)
                begin
                    if (qbetter)
                    begin
                        tok_next.have = 1'b1;
                        tok_next.m    = s_reg;
                        tok_next.c    = t_reg;
                        tok_next.bv   = qv_reg;
                    end
                    state_next = S_SEND;
                end
                else if (!nv_reg || LAST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    // The line that loses at the midpoint goes down.
                    if (bmid)
                    begin
                        tok_next.m = s_reg;
                        tok_next.c = t_reg;
                    end
                    state_next = S_SEND;
                end
                if (!LAST)
                begin
                    tok_next.idx = {tok_reg.idx[lcmlt_pkg::IDX_W-2:0], !go_left};
                    if (!go_left)
                    begin
                        tok_next.lo = mid;
                    end
                end
            end
            S_SEND:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
        if (state_reg == S_READ)
        begin
            nv_reg <= rdata[lcmlt_pkg::LINE_W-1];
            s_reg  <= rdata[lcmlt_pkg::LINE_W-2 -: lcmlt_pkg::SLOPE_W];
            t_reg  <= rdata[lcmlt_pkg::ICPT_W-1:0];
            dm_reg <= lcmlt_pkg::DIFF_W'(tok_reg.m)
                      - lcmlt_pkg::DIFF_W'($signed(rdata[lcmlt_pkg::LINE_W-2 -: lcmlt_pkg::SLOPE_W]));
            dc_reg <= lcmlt_pkg::DC_W'(tok_reg.c)
                      - lcmlt_pkg::DC_W'($signed(rdata[lcmlt_pkg::ICPT_W-1:0]));
        end
        if (state_reg == S_MLO || state_reg == S_MMID)
        begin
            prod_reg <= prod;
        end
        if (state_reg == S_MMID)
        begin
            qv_reg  <= sum;
            blo_reg <= bmid;
        end
    end

    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        clr.active |-> state_reg == S_IDLE)
        else $error("clearing pass while a cell is busy");

    a_empty_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && tok_reg.op == lcmlt_pkg::OP_INSERT && !nv_reg)
        |=> state_reg == S_IDLE)
        else $error("insert into empty node did not stop");

    a_query_have: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && tok_reg.op == lcmlt_pkg::OP_QUERY && nv_reg)
        |=> (state_reg == S_SEND && tok_reg.have))
        else $error("query passed a stored line without a best line");

    a_write_in_fin: assert property (@(posedge clk) disable iff (!rst_n)
        ins_we |-> !clr.active)
        else $error("insert write during clearing pass");
endmodule
`default_nettype wire

@@ src/li_chao_min_line_tree.sv @@
`default_nettype none
// Channel   Direction  Payload
// items     in         op, line_slope, line_intercept, query_x
// results   out        found, best_slope, best_intercept, best_value (queries only)
// wr_*      in         register write: wr_index 0 range_left, 1 keep_maximum
//
// One cell per tree level, LOG_RANGE+1 cells; each cell holds one item at a time
// (accept, RAM read, two multiplies, decide, hand-off) and takes no new item until
// it is idle again, so a new item enters only after the last has left the first cell.
// A query's result is registered after the last cell and held until taken.
// After reset a clearing pass over every node address empties the tree; no item is
// taken until it ends.
// A stalled result holds the last cell, and the stall then backs up cell by cell.
module li_chao_min_line_tree #(
    parameter int LOG_RANGE = 10
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    lcmlt_in_if.sink                                items,
    lcmlt_out_if.source                             results,
    input  wire logic                               wr_en,
    input  wire logic [lcmlt_pkg::REG_IDX_W-1:0]    wr_index,
    input  wire logic [lcmlt_pkg::CFG_W-1:0]        wr_data
);
    logic signed [lcmlt_pkg::X_W-1:0] range_left_reg;
    logic                             keep_max_reg;
    logic                             clearing_reg;
    logic [LOG_RANGE-1:0]             clr_cnt_reg;
    lcmlt_pkg::clr_t                  clr;

    logic            cv [LOG_RANGE+2];
    logic            cr [LOG_RANGE+2];
    lcmlt_pkg::tok_t ct [LOG_RANGE+2];

    logic signed [lcmlt_pkg::SLOPE_W-1:0] m_sat;
    logic signed [lcmlt_pkg::ICPT_W-1:0]  c_sat;
    lcmlt_pkg::tok_t                      tok_fin;

    logic                                 res_valid_reg;
    logic                                 res_found_reg;
    logic signed [lcmlt_pkg::SLOPE_W-1:0] res_slope_reg;
    logic signed [lcmlt_pkg::ICPT_W-1:0]  res_icpt_reg;
    logic signed [lcmlt_pkg::BV_W-1:0]    res_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_left_reg <= '0;
            keep_max_reg   <= 1'b0;
        end
        else if (wr_en)
        begin
            if (wr_index == lcmlt_pkg::REG_RANGE_LEFT)
            begin
                range_left_reg <= wr_data;
            end
            else if (wr_index == lcmlt_pkg::REG_KEEP_MAXIMUM)
            begin
                keep_max_reg <= wr_data[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + LOG_RANGE'(1);
            if (&clr_cnt_reg)
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    assign clr.active = clearing_reg;
    assign clr.addr   = lcmlt_pkg::IDX_W'(clr_cnt_reg);

    always_comb
    begin
        m_sat = (items.line_slope < -lcmlt_pkg::SLOPE_LIM) ? -lcmlt_pkg::SLOPE_LIM
                                                            : items.line_slope;
        c_sat = (items.line_intercept < -lcmlt_pkg::ICPT_LIM) ? -lcmlt_pkg::ICPT_LIM
                                                               : items.line_intercept;
        ct[0].op   = items.op;
        ct[0].m    = keep_max_reg ? -m_sat : m_sat;
        ct[0].c    = keep_max_reg ? -c_sat : c_sat;
        ct[0].x    = items.query_x;
        ct[0].lo   = lcmlt_pkg::LO_W'(range_left_reg);
        ct[0].idx  = '0;
        ct[0].have = 1'b0;
        ct[0].bv   = '0;
    end

    assign cv[0]       = items.valid && !clearing_reg;
    assign items.ready = cr[0] && !clearing_reg;

    for (genvar g = 0; g <= LOG_RANGE; g++)
    begin : g_cell
        lcmlt_cell #(
            .LOG_RANGE (LOG_RANGE),
            .LEVEL     (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .clr       (clr),
            .in_valid  (cv[g]),
            .in_ready  (cr[g]),
            .in_tok    (ct[g]),
            .out_valid (cv[g+1]),
            .out_ready (cr[g+1]),
            .out_tok   (ct[g+1])
        );
    end

    assign tok_fin          = ct[LOG_RANGE+1];
    assign cr[LOG_RANGE+1]  = !res_valid_reg || results.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cv[LOG_RANGE+1] && cr[LOG_RANGE+1])
        begin
            res_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Lines are stored negated in maximum mode; undo that on the way out.
    always_ff @(posedge clk)
    begin
        if (cv[LOG_RANGE+1] && cr[LOG_RANGE+1])
        begin
            res_found_reg <= tok_fin.have;
            if (!tok_fin.have)
            begin
                res_slope_reg <= '0;
                res_icpt_reg  <= '0;
                res_value_reg <= '0;
            end
            else if (keep_max_reg)
            begin
                res_slope_reg <= -tok_fin.m;
                res_icpt_reg  <= -tok_fin.c;
                res_value_reg <= lcmlt_pkg::BV_W'(-tok_fin.bv);
            end
            else
            begin
                res_slope_reg <= tok_fin.m;
                res_icpt_reg  <= tok_fin.c;
                res_value_reg <= lcmlt_pkg::BV_W'(tok_fin.bv);
            end
        end
    end

    assign results.valid          = res_valid_reg;
    assign results.found          = res_found_reg;
    assign results.best_slope     = res_slope_reg;
    assign results.best_intercept = res_icpt_reg;
    assign results.best_value     = res_value_reg;
endmodule
`default_nettype wire

@@ tb/tb_li_chao_min_line_tree.sv @@
`default_nettype none
module tb_li_chao_min_line_tree;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LOG_R = 10;
    localparam int NODES = 1 << (LOG_R + 1);
    localparam int DRAIN = 5 * (LOG_R + 1) + 20;

    typedef struct {
        logic                                 found;
        logic signed [lcmlt_pkg::SLOPE_W-1:0] m;
        logic signed [lcmlt_pkg::ICPT_W-1:0]  c;
        logic signed [lcmlt_pkg::BV_W-1:0]    v;
    } answer_t;

    logic clk;
    logic rst_n;
    logic wr_en;
    logic [lcmlt_pkg::REG_IDX_W-1:0] wr_index;
    logic [lcmlt_pkg::CFG_W-1:0] wr_data;

    lcmlt_in_if  items ();
    lcmlt_out_if results ();

    li_chao_min_line_tree #(.LOG_RANGE(LOG_R)) DUT (
        .clk(clk), .rst_n(rst_n), .items(items), .results(results),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
    );

    // Shadow copy of the tree.
    longint t_m [NODES];
    longint t_c [NODES];
    bit     t_v [NODES];
    longint cur_left;
    bit     cur_max;

    answer_t answer_q [$];
    int errors;
    int send_idle_pct;
    int recv_stall_pct;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic longint sat(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    task automatic predict_item(logic op, logic signed [lcmlt_pkg::SLOPE_W-1:0] s,
                                logic signed [lcmlt_pkg::ICPT_W-1:0] ic,
                                logic signed [lcmlt_pkg::X_W-1:0] qx);
        longint m, c, x, lo, w, mid, tm, tc, v, bm, bc, bv;
        int n, k;
        bit blo, bmid, have;
        answer_t a;
        m = sat(longint'(s), longint'(lcmlt_pkg::SLOPE_LIM));
        c = sat(longint'(ic), longint'(lcmlt_pkg::ICPT_LIM));
        x = longint'(qx);
        lo = cur_left;
        w = 1 << LOG_R;
        n = 1;
        if (op == lcmlt_pkg::OP_INSERT)
        begin
            if (cur_max)
            begin
                m = -m;
                c = -c;
            end
            forever
            begin
                mid = lo + w / 2;
                k = n & (NODES - 1);
                if (!t_v[k])
                begin
                    t_m[k] = m;
                    t_c[k] = c;
                    t_v[k] = 1;
                    break;
                end
                blo = (m * lo + c) < (t_m[k] * lo + t_c[k]);
                bmid = (m * mid + c) < (t_m[k] * mid + t_c[k]);
                if (bmid)
                begin
                    tm = t_m[k];
                    tc = t_c[k];
                    t_m[k] = m;
                    t_c[k] = c;
                    m = tm;
                    c = tc;
                end
                if (w <= 1) break;
                if (blo != bmid) n = 2 * n;
                else
                begin
                    n = 2 * n + 1;
                    lo = mid;
                end
                w = w / 2;
            end
        end
        else
        begin
            have = 0;
            bm = 0;
            bc = 0;
            bv = 0;
            forever
            begin
                mid = lo + w / 2;
                k = n & (NODES - 1);
                if (t_v[k])
                begin
                    v = t_m[k] * x + t_c[k];
                    if (!have || v < bv)
                    begin
                        have = 1;
                        bm = t_m[k];
                        bc = t_c[k];
                        bv = v;
                    end
                end
                if (w <= 1) break;
                if (x < mid) n = 2 * n;
                else
                begin
                    n = 2 * n + 1;
                    lo = mid;
                end
                w = w / 2;
            end
            if (have && cur_max)
            begin
                bm = -bm;
                bc = -bc;
            end
            a.found = have;
            a.m = bm[lcmlt_pkg::SLOPE_W-1:0];
            a.c = bc[lcmlt_pkg::ICPT_W-1:0];
            if (have) a.v = lcmlt_pkg::BV_W'(bm * x + bc);
            else a.v = '0;
            answer_q.push_back(a);
        end
    endtask

    task automatic send_item(logic op, logic signed [lcmlt_pkg::SLOPE_W-1:0] s,
                             logic signed [lcmlt_pkg::ICPT_W-1:0] ic,
                             logic signed [lcmlt_pkg::X_W-1:0] qx);
        if ($urandom_range(99) < send_idle_pct)
        begin
            items.valid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < send_idle_pct) @(negedge clk);
        end
        items.valid <= 1'b1;
        items.op <= op;
        items.line_slope <= s;
        items.line_intercept <= ic;
        items.query_x <= qx;
        @(posedge clk);
        while (!items.ready) @(posedge clk);
        predict_item(op, s, ic, qx);
        @(negedge clk);
    endtask

    // Receiver stall.
    initial
    begin
        results.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            results.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result checker.
    always @(posedge clk)
    begin
        answer_t a;
        if (rst_n && results.valid && results.ready)
        begin
            if (answer_q.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected result transaction");
            end
            else
            begin
                a = answer_q.pop_front();
                if (results.found !== a.found || results.best_slope !== a.m ||
                    results.best_intercept !== a.c || results.best_value !== a.v)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                                 a.found, a.m, a.c, a.v, results.found,
                                 results.best_slope, results.best_intercept,
                                 results.best_value);
                end
            end
        end
    end

    task automatic wait_idle();
        int guard;
        items.valid <= 1'b0;
        guard = 0;
        while (answer_q.size() != 0 && guard < 200000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (DRAIN) @(negedge clk);
    endtask

    task automatic write_reg(logic [lcmlt_pkg::REG_IDX_W-1:0] idx,
                             logic [lcmlt_pkg::CFG_W-1:0] val);
        wait_idle();
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        @(negedge clk);
        wr_en <= 1'b0;
        if (idx == lcmlt_pkg::REG_RANGE_LEFT) cur_left = longint'($signed(val));
        else if (idx == lcmlt_pkg::REG_KEEP_MAXIMUM) cur_max = val[0];
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_query(logic signed [lcmlt_pkg::X_W-1:0] qx);
        send_item(lcmlt_pkg::OP_QUERY, $urandom, lcmlt_pkg::ICPT_W'(rnd64()), qx);
    endtask

    task automatic send_insert(logic signed [lcmlt_pkg::SLOPE_W-1:0] s,
                               logic signed [lcmlt_pkg::ICPT_W-1:0] ic);
        send_item(lcmlt_pkg::OP_INSERT, s, ic, lcmlt_pkg::X_W'($urandom));
    endtask

    task automatic test_directed();
        send_query(16'sd5);
        send_insert(32'sh8000_0000, 48'sh8000_0000_0000);
        send_insert(32'sh7fff_ffff, 48'sh7fff_ffff_ffff);
        send_insert(32'sd3, 48'sd10);
        send_insert(32'sd3, 48'sd10);
        send_insert(-32'sd2, 48'sd100);
        send_insert(32'sd0, -48'sd5);
        send_query(16'sh8000);
        send_query(16'sh7fff);
        send_query(16'sd0);
        send_query(16'sd1023);
        send_query(16'sd512);
        send_query(-16'sd1);
    endtask

    // Mostly queries inside the domain so paths overlap the inserted lines.
    task automatic test_random(int count, int max_slope_bits);
        int sb;
        logic signed [lcmlt_pkg::SLOPE_W-1:0] s;
        logic signed [lcmlt_pkg::ICPT_W-1:0] ic;
        logic signed [lcmlt_pkg::X_W-1:0] qx;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 45)
            begin
                sb = $urandom_range(max_slope_bits, 1);
                s = lcmlt_pkg::SLOPE_W'($signed(rnd64()) >>> (64 - sb));
                ic = lcmlt_pkg::ICPT_W'($signed(rnd64()) >>> $urandom_range(16, 60));
                if ($urandom_range(19) == 0) ic = lcmlt_pkg::ICPT_W'(rnd64());
                if ($urandom_range(19) == 0) s = $urandom;
                send_insert(s, ic);
            end
            else
            begin
                if ($urandom_range(9) == 0) qx = lcmlt_pkg::X_W'($urandom);
                else qx = lcmlt_pkg::X_W'(cur_left + $urandom_range(1023));
                send_query(qx);
            end
        end
    endtask

    task automatic test_max_mode();
        write_reg(lcmlt_pkg::REG_KEEP_MAXIMUM, 16'd1);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random(150, 32);
        write_reg(lcmlt_pkg::REG_RANGE_LEFT, 16'h8000);
        test_random(100, 20);
        write_reg(lcmlt_pkg::REG_KEEP_MAXIMUM, 16'd0);
        write_reg(lcmlt_pkg::REG_RANGE_LEFT, 16'h7fff);
        test_random(100, 32);
        write_reg(8'd7, 16'hffff);
    endtask

    initial
    begin
        errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        cur_left = 0;
        cur_max = 0;
        foreach (t_v[i]) t_v[i] = 0;
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        items.valid = 1'b0;
        items.op = lcmlt_pkg::OP_INSERT;
        items.line_slope = '0;
        items.line_intercept = '0;
        items.query_x = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        write_reg(lcmlt_pkg::REG_RANGE_LEFT, 16'hfe00);
        test_directed();
        test_random(250, 20);
        send_idle_pct = 56;
        test_random(200, 32);
        wait_idle();
        send_idle_pct = 0;
        recv_stall_pct = 56;
        test_random(200, 12);
        send_idle_pct = 33;
        recv_stall_pct = 33;
        test_random(250, 32);
        test_max_mode();
        wait_idle();
        if (errors == 0 && answer_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
